>>> rtl/quic_flow_credit_tracker_core_macros.svh
// Assertion macros shared by the checker of the flow credit tracker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef QUIC_FLOW_CREDIT_TRACKER_CORE_MACROS_SVH
`define QUIC_FLOW_CREDIT_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QFCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("flow credit tracker check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QFCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("flow credit tracker check failed");

`endif

>>> rtl/quic_fct_pkg.sv
// Types and constants of the flow credit tracker.
// No dependencies; used by the update logic and the top level.
package quic_fct_pkg;

  localparam int unsigned REG_W  = 62;
  localparam int unsigned AMT_W  = 64;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned APB_W  = 64;

  typedef enum logic [3:0] {
    CMD_INIT         = 4'd0,
    CMD_CHECK_SEND   = 4'd1,
    CMD_CONSUME_SEND = 4'd2,
    CMD_CONSUME_RECV = 4'd3,
    CMD_SET_SEND_MAX = 4'd4,
    CMD_SET_RECV_MAX = 4'd5,
    CMD_SET_BIDI_MAX = 4'd6,
    CMD_SET_UNI_MAX  = 4'd7,
    CMD_OPEN_BIDI    = 4'd8,
    CMD_OPEN_UNI     = 4'd9,
    CMD_CLOSE_BIDI   = 4'd10,
    CMD_CLOSE_UNI    = 4'd11
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] CFG_RECV_LIMIT = 2'd0;
  localparam logic [1:0] CFG_SEND_LIMIT = 2'd1;
  localparam logic [1:0] CFG_BIDI_LIMIT = 2'd2;
  localparam logic [1:0] CFG_UNI_LIMIT  = 2'd3;

  localparam logic [REG_W-1:0] RST_BYTE_LIMIT   = 62'd1048576;
  localparam logic [REG_W-1:0] RST_STREAM_LIMIT = 62'd100;

  typedef struct packed {
    logic [REG_W-1:0] sent_bytes;
    logic [REG_W-1:0] received_bytes;
    logic [REG_W-1:0] send_limit;
    logic [REG_W-1:0] recv_limit;
    logic [REG_W-1:0] bidi_open_count;
    logic [REG_W-1:0] uni_open_count;
    logic [REG_W-1:0] bidi_limit;
    logic [REG_W-1:0] uni_limit;
  } credit_state_t;

  typedef struct packed {
    logic [REG_W-1:0] recv_limit;
    logic [REG_W-1:0] send_limit;
    logic [REG_W-1:0] bidi_limit;
    logic [REG_W-1:0] uni_limit;
  } init_cfg_t;

endpackage

>>> rtl/quic_fct_update.sv
// Next-state and status logic for one command of the flow credit tracker.
// Depends on quic_fct_pkg; purely combinational, used by the top level.
module quic_fct_update
  import quic_fct_pkg::*;
#(
  parameter logic [AMT_W-1:0] WinMax = 64'h3FFF_FFFF_FFFF_FFFF
) (
  input  credit_state_t    state_i,
  input  init_cfg_t        cfg_i,
  input  logic [3:0]       cmd_i,
  input  logic [AMT_W-1:0] amount_i,
  output credit_state_t    state_o,
  output status_e          status_o,
  output logic             allowed_o
);

  logic [REG_W-1:0] byte_ctr;
  logic [REG_W-1:0] byte_lim;
  logic [AMT_W:0]   byte_sum;
  logic             sum_wraps;
  logic             sum_over;
  logic [REG_W-1:0] cur_lim;
  logic             amt_too_big;
  logic             amt_below;

  // One adder serves check, consume send and consume recv.
  assign byte_ctr  = (cmd_i == CMD_CONSUME_RECV) ? state_i.received_bytes : state_i.sent_bytes;
  assign byte_lim  = (cmd_i == CMD_CONSUME_RECV) ? state_i.recv_limit : state_i.send_limit;
  assign byte_sum  = {1'b0, amount_i} + {3'b000, byte_ctr};
  assign sum_wraps = byte_sum[AMT_W];
  assign sum_over  = byte_sum[AMT_W-1:0] > {2'b00, byte_lim};

  always_comb begin
    case (cmd_i)
      CMD_SET_BIDI_MAX: cur_lim = state_i.bidi_limit;
      CMD_SET_UNI_MAX:  cur_lim = state_i.uni_limit;
      default:          cur_lim = state_i.send_limit;
    endcase
  end

  assign amt_too_big = amount_i > WinMax;
  assign amt_below   = amount_i < {2'b00, cur_lim};

  always_comb begin
    state_o   = state_i;
    status_o  = ST_OK;
    allowed_o = 1'b0;
    case (cmd_i)
      CMD_INIT: begin
        if ({2'b00, cfg_i.recv_limit} > WinMax || {2'b00, cfg_i.send_limit} > WinMax) begin
          status_o = ST_OVERFLOW;
        end else begin
          state_o.sent_bytes      = '0;
          state_o.received_bytes  = '0;
          state_o.bidi_open_count = '0;
          state_o.uni_open_count  = '0;
          state_o.recv_limit      = cfg_i.recv_limit;
          state_o.send_limit      = cfg_i.send_limit;
          state_o.bidi_limit      = cfg_i.bidi_limit;
          state_o.uni_limit       = cfg_i.uni_limit;
        end
      end
      CMD_CHECK_SEND: begin
        allowed_o = !sum_wraps && !sum_over;
      end
      CMD_CONSUME_SEND, CMD_CONSUME_RECV: begin
        if (sum_wraps) begin
          status_o = ST_OVERFLOW;
        end else if (sum_over) begin
          status_o = ST_BLOCKED;
        end else if (cmd_i == CMD_CONSUME_RECV) begin
          state_o.received_bytes = byte_sum[REG_W-1:0];
        end else begin
          state_o.sent_bytes = byte_sum[REG_W-1:0];
        end
      end
      CMD_SET_SEND_MAX, CMD_SET_BIDI_MAX, CMD_SET_UNI_MAX: begin
        if (amt_too_big) begin
          status_o = ST_OVERFLOW;
        end else if (amt_below) begin
          status_o = ST_INVALID;
        end else if (cmd_i == CMD_SET_SEND_MAX) begin
          state_o.send_limit = amount_i[REG_W-1:0];
        end else if (cmd_i == CMD_SET_BIDI_MAX) begin
          state_o.bidi_limit = amount_i[REG_W-1:0];
        end else begin
          state_o.uni_limit = amount_i[REG_W-1:0];
        end
      end
      CMD_SET_RECV_MAX: begin
        if (amt_too_big) begin
          status_o = ST_OVERFLOW;
        end else begin
          state_o.recv_limit = amount_i[REG_W-1:0];
        end
      end
      CMD_OPEN_BIDI: begin
        if (state_i.bidi_open_count >= state_i.bidi_limit) begin
          status_o = ST_BLOCKED;
        end else begin
          state_o.bidi_open_count = state_i.bidi_open_count + REG_W'(1);
        end
      end
      CMD_OPEN_UNI: begin
        if (state_i.uni_open_count >= state_i.uni_limit) begin
          status_o = ST_BLOCKED;
        end else begin
          state_o.uni_open_count = state_i.uni_open_count + REG_W'(1);
        end
      end
      CMD_CLOSE_BIDI: begin
        if (state_i.bidi_open_count == '0) begin
          status_o = ST_INVALID;
        end else begin
          state_o.bidi_open_count = state_i.bidi_open_count - REG_W'(1);
        end
      end
      CMD_CLOSE_UNI: begin
        if (state_i.uni_open_count == '0) begin
          status_o = ST_INVALID;
        end else begin
          state_o.uni_open_count = state_i.uni_open_count - REG_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/quic_flow_credit_tracker_core.sv
// Top level of the connection flow credit tracker: APB registers, a
// three-stage command pipeline and the credit state. Uses quic_fct_pkg
// and quic_fct_update.
//
//  channel   dir  signals                                  payload
//  s_axis    in   tvalid/tready/tuser[3:0]/tdata[63:0]     cmd, amount
//  m_axis    out  tvalid/tready/tdata[135:0]               status, windows, allowed flags
//  apb       in   psel/penable/pwrite/paddr                four initial limit registers
//
// A command passes the input register, state update and window calculation
// on its way to the result. One command is accepted per cycle while the output
// is not stalled; the state update stage's adder and compare set the clock
// period. A stalled result holds the pipeline behind it. Reset loads the limits
// with their register reset values and clears all counters and valid flags.
module quic_flow_credit_tracker_core
  import quic_fct_pkg::*;
#(
  parameter int unsigned LIMIT_WIDTH = 62
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] cmd
  input  logic [3:0]        s_axis_tuser,
  // [63:0] amount
  input  logic [63:0]       s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [1:0] status, [2] send_allowed, [64:3] send_window, [126:65] recv_window,
  // [127] bidi_open_allowed, [128] uni_open_allowed, [135:129] zero
  output logic [135:0]      m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  localparam logic [AMT_W-1:0] WinMax = (64'd1 << LIMIT_WIDTH) - 64'd1;

  // Configuration registers.
  init_cfg_t cfg_q;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recv_limit <= RST_BYTE_LIMIT;
      cfg_q.send_limit <= RST_BYTE_LIMIT;
      cfg_q.bidi_limit <= RST_STREAM_LIMIT;
      cfg_q.uni_limit  <= RST_STREAM_LIMIT;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        CFG_RECV_LIMIT: cfg_q.recv_limit <= pwdata[REG_W-1:0];
        CFG_SEND_LIMIT: cfg_q.send_limit <= pwdata[REG_W-1:0];
        CFG_BIDI_LIMIT: cfg_q.bidi_limit <= pwdata[REG_W-1:0];
        CFG_UNI_LIMIT:  cfg_q.uni_limit  <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      CFG_RECV_LIMIT: prdata = {2'b00, cfg_q.recv_limit};
      CFG_SEND_LIMIT: prdata = {2'b00, cfg_q.send_limit};
      CFG_BIDI_LIMIT: prdata = {2'b00, cfg_q.bidi_limit};
      CFG_UNI_LIMIT:  prdata = {2'b00, cfg_q.uni_limit};
      default:        prdata = '0;
    endcase
  end

  // Pipeline handshake.
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic s0_load, s1_load, s2_load;

  assign s2_load       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s1_load       = s0_valid_q && (!s1_valid_q || s2_load);
  assign s_axis_tready = !s0_valid_q || s1_load;
  assign s0_load       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_load) begin
        s0_valid_q <= 1'b1;
      end else if (s1_load) begin
        s0_valid_q <= 1'b0;
      end
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register.
  logic [3:0]       s0_cmd_q;
  logic [AMT_W-1:0] s0_amount_q;

  always_ff @(posedge clk_i) begin
    if (s0_load) begin
      s0_cmd_q    <= s_axis_tuser;
      s0_amount_q <= s_axis_tdata;
    end
  end

  // State update stage.
  credit_state_t state_q, state_d;
  status_e       upd_status;
  logic          upd_allowed;
  status_e       s1_status_q;
  logic          s1_allowed_q;

  quic_fct_update #(
    .WinMax (WinMax)
  ) u_update (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .cmd_i     (s0_cmd_q),
    .amount_i  (s0_amount_q),
    .state_o   (state_d),
    .status_o  (upd_status),
    .allowed_o (upd_allowed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.sent_bytes      <= '0;
      state_q.received_bytes  <= '0;
      state_q.send_limit      <= RST_BYTE_LIMIT;
      state_q.recv_limit      <= RST_BYTE_LIMIT;
      state_q.bidi_open_count <= '0;
      state_q.uni_open_count  <= '0;
      state_q.bidi_limit      <= RST_STREAM_LIMIT;
      state_q.uni_limit       <= RST_STREAM_LIMIT;
    end else if (s1_load) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_status_q  <= upd_status;
      s1_allowed_q <= upd_allowed;
    end
  end

  // Window stage. The state only moves on when stage one loads, so
  // state_q here is the state right after the command held in stage one.
  logic [REG_W:0]   send_diff, recv_diff;
  logic [REG_W-1:0] send_win, recv_win;
  logic             bidi_ok, uni_ok;

  assign send_diff = {1'b0, state_q.send_limit} - {1'b0, state_q.sent_bytes};
  assign recv_diff = {1'b0, state_q.recv_limit} - {1'b0, state_q.received_bytes};
  assign send_win  = send_diff[REG_W] ? '0 : send_diff[REG_W-1:0];
  assign recv_win  = recv_diff[REG_W] ? '0 : recv_diff[REG_W-1:0];
  assign bidi_ok   = state_q.bidi_open_count < state_q.bidi_limit;
  assign uni_ok    = state_q.uni_open_count < state_q.uni_limit;

  logic [135:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_data_q <= {7'd0, uni_ok, bidi_ok, recv_win, send_win, s1_allowed_q, s1_status_q};
    end
  end

  assign m_axis_tdata = out_data_q;

endmodule

>>> rtl/quic_fct_checker.sv
// Port-level checker for the flow credit tracker, bound to the top level.
// Uses quic_fct_pkg and the macros of quic_flow_credit_tracker_core_macros.svh.
`include "quic_flow_credit_tracker_core_macros.svh"

module quic_fct_port_checker
  import quic_fct_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  logic       in_xfer, out_xfer;
  logic [2:0] inflight_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Commands accepted whose results have not been transferred yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  `QFCT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
  `QFCT_ASSERT_NOW(a_allowed_ok, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1:0] == ST_OK)
  `QFCT_ASSERT_NOW(a_result_has_cmd, m_axis_tvalid, inflight_q != 3'd0)
  `QFCT_ASSERT_NOW(a_depth, 1'b1, inflight_q <= 3'd3)

endmodule

bind quic_flow_credit_tracker_core quic_fct_port_checker u_quic_fct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
